>>> src/tpm_pkg.sv
package tpm_pkg;

    localparam int PAGE_DEPTH = 1024;
    localparam int PAGE_AW    = $clog2(PAGE_DEPTH);
    localparam int ROWS       = 24;
    localparam int SLICES     = 10;

    // one bus access
    typedef struct packed {
        logic       operation;
        logic       command_side;
        logic       latch_b;
        logic [7:0] write_data;
        logic [7:0] ext_read_data;
    } access_t;

    // result of one bus access
    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  ext_kind;
        logic [19:0] ext_address;
        logic [7:0]  ext_write_data;
    } reply_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    localparam logic [1:0] EXT_NONE      = 2'd0;
    localparam logic [1:0] EXT_MEM_READ  = 2'd1;
    localparam logic [1:0] EXT_MEM_WRITE = 2'd2;
    localparam logic [1:0] EXT_ROM_READ  = 2'd3;

    // command selector, bits 7:5 of a command write on latch B
    localparam logic [2:0] CMD_LOAD_XY   = 3'd0;
    localparam logic [2:0] CMD_LOAD_Y    = 3'd1;
    localparam logic [2:0] CMD_LOAD_X    = 3'd2;
    localparam logic [2:0] CMD_STEP      = 3'd3;
    localparam logic [2:0] CMD_LOAD_MODE = 3'd4;
    localparam logic [2:0] CMD_LOAD_R    = 3'd5;
    localparam logic [2:0] CMD_LOAD_Y0   = 3'd6;

    // access mode, bits 7:5 of the mode byte
    localparam logic [2:0] MODE_WRITE_STEP  = 3'd0;
    localparam logic [2:0] MODE_READ_STEP   = 3'd1;
    localparam logic [2:0] MODE_WRITE       = 3'd2;
    localparam logic [2:0] MODE_READ        = 3'd3;
    localparam logic [2:0] MODE_SLICE_WRITE = 3'd4;
    localparam logic [2:0] MODE_SLICE_READ  = 3'd5;

    localparam logic [7:0] EXMEM_CODE_MIN = 8'ha0;
    localparam logic [7:0] ROM_CODE_LIMIT = 8'h80;
    localparam logic [7:0] SLICE_FILL     = 8'hff;

endpackage

>>> src/tpm_ram.sv
module tpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/teletext_page_memory_bus_port_unit.sv
// CPU bus port of a teletext page memory. One bus access is taken per item and gives one
// reply item. The page memory (attribute and code bytes side by side, one read and one
// write port) is read at the cursor address in the cycle the item is accepted, and in the
// next cycle the item is executed (the entry written back in the write modes) and the reply
// register is loaded; if the previous reply is still stalled there, the item waits. A new
// item is taken only after the last one has been executed. After reset a clearing pass
// writes zero to all 1024 entries, one per cycle, and access_stall stays high throughout.
module teletext_page_memory_bus_port_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             access_valid,
    output logic             access_stall,
    input  tpm_pkg::access_t access,
    output logic             reply_valid,
    input  logic             reply_stall,
    output tpm_pkg::reply_t  reply
);

    import tpm_pkg::*;

    state_t               state_reg, state_next;
    logic [PAGE_AW-1:0]   clr_reg, clr_next;
    access_t              item_reg;
    logic [PAGE_AW-1:0]   addr_reg;
    logic [7:0]           latch_a_reg, latch_a_next;
    logic [7:0]           latch_b_reg, latch_b_next;
    logic [5:0]           col_reg, col_next;
    logic [4:0]           row_reg, row_next;
    logic [7:0]           mode_reg, mode_next;
    logic [5:0]           origin_reg, origin_next;
    reply_t               reply_reg, reply_next;
    logic                 reply_valid_reg, reply_valid_next;

    logic                 accept;
    logic                 commit;
    logic [PAGE_AW-1:0]   cur_addr;
    logic                 ram_we;
    logic [PAGE_AW-1:0]   ram_waddr;
    logic [15:0]          ram_wdata;
    logic [15:0]          ram_rdata;
    logic [7:0]           attr;
    logic [7:0]           code;
    logic [3:0]           slice;
    logic [4:0]           slice_inc;
    logic [3:0]           slice_wrap;
    logic [10:0]          stepped;
    logic [7:0]           rom_char;

    function automatic logic [10:0] step_cursor(input logic [5:0] col, input logic [4:0] row);
        logic [6:0]  c1;
        logic [4:0]  r1;
        logic [10:0] res;
        c1  = {1'b0, col} + 7'd1;
        r1  = row + 5'd1;
        res = {row, c1[5:0]};
        if (c1 == 7'd40 || c1 == 7'd48 || c1 == 7'd56 || c1 == 7'd64)
        begin
            if (r1 == 5'(ROWS))
            begin
                r1 = '0;
            end
            res = {r1, 6'd0};
        end
        return res;
    endfunction

    // rows 24..31 and columns 32..63 fold into the spare area from 0x300 upwards
    function automatic logic [PAGE_AW-1:0] cursor_address(input logic [5:0] x,
                                                          input logic [4:0] y);
        logic [PAGE_AW-1:0] a;
        if (y[4:3] == 2'b11)
        begin
            a = {2'b11, x[5:3], 2'b11, x[2:0]};
        end
        else if (x[5])
        begin
            a = {2'b11, y[2:0], y[4:3], x[2:0]};
        end
        else
        begin
            a = {y[4:0], x[4:0]};
        end
        return a;
    endfunction

    assign access_stall = (state_reg != ST_IDLE);
    assign accept       = access_valid && !access_stall;
    assign commit       = (state_reg == ST_EXEC) && (!reply_valid_reg || !reply_stall);
    assign cur_addr     = cursor_address(col_reg, row_reg);

    assign attr       = ram_rdata[15:8];
    assign code       = ram_rdata[7:0];
    assign slice      = mode_reg[3:0];
    assign slice_inc  = {1'b0, slice} + 5'd1;
    assign slice_wrap = (slice_inc >= 5'(SLICES)) ? 4'(slice_inc - 5'(SLICES))
                                                  : slice_inc[3:0];
    assign stepped    = step_cursor(col_reg, row_reg);
    assign rom_char   = {attr[7], code[6:0]};

    tpm_ram #(
        .WIDTH(16),
        .DEPTH(PAGE_DEPTH)
    ) u_page_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(cur_addr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            reply_valid_reg <= 1'b0;
            latch_a_reg     <= '0;
            latch_b_reg     <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            mode_reg        <= '0;
            origin_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            reply_valid_reg <= reply_valid_next;
            latch_a_reg     <= latch_a_next;
            latch_b_reg     <= latch_b_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            mode_reg        <= mode_next;
            origin_reg      <= origin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= access;
            addr_reg <= cur_addr;
        end
        if (commit)
        begin
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        latch_a_next     = latch_a_reg;
        latch_b_next     = latch_b_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        mode_next        = mode_reg;
        origin_next      = origin_reg;
        reply_next       = '0;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = {latch_a_reg, item_reg.write_data};
        reply_valid_next = reply_valid_reg && reply_stall;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == PAGE_AW'(PAGE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next       = ST_IDLE;
                    reply_valid_next = 1'b1;
                    if (!item_reg.operation)
                    begin
                        if (!item_reg.latch_b)
                        begin
                            latch_a_next = item_reg.write_data;
                        end
                        else if (item_reg.command_side)
                        begin
                            latch_b_next = item_reg.write_data;
                            case (item_reg.write_data[7:5])
                                CMD_LOAD_XY:
                                begin
                                    col_next = '0;
                                    row_next = latch_a_reg[4:0];
                                end
                                CMD_LOAD_Y:    row_next    = latch_a_reg[4:0];
                                CMD_LOAD_X:    col_next    = latch_a_reg[5:0];
                                CMD_STEP:      {row_next, col_next} = stepped;
                                CMD_LOAD_MODE: mode_next   = latch_a_reg;
                                CMD_LOAD_Y0:   origin_next = latch_a_reg[5:0];
                                default:       ;
                            endcase
                        end
                        else
                        begin
                            latch_b_next = item_reg.write_data;
                            case (mode_reg[7:5])
                                MODE_WRITE_STEP:
                                begin
                                    ram_we = 1'b1;
                                    {row_next, col_next} = stepped;
                                end
                                MODE_WRITE:
                                begin
                                    ram_we = 1'b1;
                                end
                                MODE_SLICE_WRITE:
                                begin
                                    if (code >= EXMEM_CODE_MIN)
                                    begin
                                        reply_next.ext_kind       = EXT_MEM_WRITE;
                                        reply_next.ext_address    = {attr, code, slice};
                                        reply_next.ext_write_data = latch_a_reg;
                                    end
                                    mode_next = {mode_reg[7:4], slice_wrap};
                                end
                                default: ;
                            endcase
                        end
                    end
                    else if (item_reg.command_side)
                    begin
                        // busy flag reads ready, latch B side reads zero
                        reply_next.read_data = '0;
                    end
                    else if (!item_reg.latch_b)
                    begin
                        reply_next.read_data = latch_a_reg;
                    end
                    else
                    begin
                        reply_next.read_data = latch_b_reg;
                        case (mode_reg[7:5])
                            MODE_READ_STEP:
                            begin
                                latch_a_next = attr;
                                latch_b_next = code;
                                {row_next, col_next} = stepped;
                            end
                            MODE_READ:
                            begin
                                latch_a_next = attr;
                                latch_b_next = code;
                            end
                            MODE_SLICE_READ:
                            begin
                                latch_a_next = SLICE_FILL;
                                latch_b_next = SLICE_FILL;
                                if (code >= EXMEM_CODE_MIN)
                                begin
                                    reply_next.ext_kind    = EXT_MEM_READ;
                                    reply_next.ext_address = {attr, code, slice};
                                    latch_a_next           = item_reg.ext_read_data;
                                end
                                else if (code < ROM_CODE_LIMIT && slice < 4'(SLICES))
                                begin
                                    reply_next.ext_kind    = EXT_ROM_READ;
                                    reply_next.ext_address = 20'(rom_char) * 20'(SLICES)
                                                           + 20'(slice);
                                    latch_a_next           = item_reg.ext_read_data;
                                end
                                mode_next = {mode_reg[7:4], slice_wrap};
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted item did not enter execution");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || commit))
        else $error("page memory written outside clearing or commit");

    a_reply_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(reply_valid_reg) |-> $past(commit))
        else $error("reply appeared without a committed item");

    a_no_ext_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid_reg && reply_reg.ext_kind == EXT_NONE) |->
            (reply_reg.ext_address == '0 && reply_reg.ext_write_data == '0))
        else $error("external fields set on a reply with no external access");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(accept))
        else $error("item accepted during clearing pass");
`endif

endmodule
